FILE: rtl/pva_pkg.sv
// ============================================================================
// pva_pkg
// Shared constants, codes and types of the persistent versioned array.
// ============================================================================
package pva_pkg;

  // Sizing
  localparam int MAX_ELEMENTS = 1024;
  localparam int MAX_VERSIONS = 4096;
  localparam int POOL_NODES   = 65536;

  // Field widths
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;
  localparam int VALUE_W  = 32;
  localparam int IDX_W    = $clog2(MAX_ELEMENTS);
  localparam int LEN_W    = IDX_W + 1;
  localparam int VER_W    = $clog2(MAX_VERSIONS);
  localparam int VCNT_W   = VER_W + 1;
  localparam int NODE_W   = $clog2(POOL_NODES);
  localparam int FREE_W   = NODE_W + 1;

  // A pool word is either a leaf value or a pair of child pointers
  localparam int WORD_W = (2 * NODE_W > VALUE_W) ? 2 * NODE_W : VALUE_W;

  // Request codes
  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_CREATE = 2'd1,
    MODE_GET    = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  // Result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_VER = 2'd1,
    ST_BAD_IDX = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  // Engine states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_ROOT,
    S_WALK,
    S_RESP
  } state_t;

  // Node pool port request
  typedef struct packed {
    logic              rd_en;
    logic [NODE_W-1:0] rd_addr;
    logic              wr_en;
    logic [NODE_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
  } pool_req_t;

  // Version root table port request
  typedef struct packed {
    logic              rd_en;
    logic [VER_W-1:0]  rd_addr;
    logic              wr_en;
    logic [VER_W-1:0]  wr_addr;
    logic [NODE_W-1:0] wr_data;
  } root_req_t;

endpackage

FILE: rtl/pva_in_if.sv
// ============================================================================
// pva_in_if
// Request channel: valid/ready handshake with one request per transfer.
// ============================================================================
interface pva_in_if;

  logic                                valid;
  logic                                ready;
  logic [pva_pkg::MODE_W-1:0]          mode;
  logic [pva_pkg::VER_W-1:0]           version;
  logic [pva_pkg::IDX_W-1:0]           index;
  logic signed [pva_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output mode, output version, output index,
                  output value, input ready);
  modport sink   (input valid, input mode, input version, input index,
                  input value, output ready);

endinterface

FILE: rtl/pva_out_if.sv
// ============================================================================
// pva_out_if
// Result channel: valid/ready handshake with one result per transfer.
// ============================================================================
interface pva_out_if;

  logic                                valid;
  logic                                ready;
  logic signed [pva_pkg::VALUE_W-1:0]  data;
  logic [pva_pkg::STATUS_W-1:0]        status;

  modport source (output valid, output data, output status, input ready);
  modport sink   (input valid, input data, input status, output ready);

endinterface

FILE: rtl/persistent_versioned_array.sv
// ============================================================================
// persistent_versioned_array
// Versioned array kept as a persistent binary tree in an on-chip node pool.
// ============================================================================
// Every request gives exactly one result. A request is taken only while the
// engine is idle and walks one root-to-leaf path at one node per cycle
// through the node pool RAM, whose single read port feeds the next address.
// With d = ceil(log2(array_length)) (10 for 1024 elements) a path holds at
// most d branch nodes above its leaf. A create or get first reads its version
// root from the root table; errors and the unused code skip the walk. The
// engine takes the next request once the result has gone to the output register.
// The result sits in an output register, so a new request is taken while it
// waits. Both RAMs come up undefined and need no clearing pass: entries are
// read only after they are written. A length write discards all versions.
// ============================================================================
module persistent_versioned_array (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [pva_pkg::LEN_W-1:0]  cfg_wdata,
  pva_in_if.sink                     in_ch,
  pva_out_if.source                  out_ch
);

  pva_pkg::pool_req_t             pool_req;
  pva_pkg::root_req_t             root_req;
  logic [pva_pkg::WORD_W-1:0]     pool_rdata;
  logic [pva_pkg::NODE_W-1:0]     root_rdata;

  // Sequencer
  pva_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .pool_req   (pool_req),
    .pool_rdata (pool_rdata),
    .root_req   (root_req),
    .root_rdata (root_rdata)
  );

  // Node pool: leaf values and child pointer pairs
  pva_ram #(
    .ADDR_W (pva_pkg::NODE_W),
    .DATA_W (pva_pkg::WORD_W)
  ) u_pool (
    .clk     (clk),
    .wr_en   (pool_req.wr_en),
    .wr_addr (pool_req.wr_addr),
    .wr_data (pool_req.wr_data),
    .rd_en   (pool_req.rd_en),
    .rd_addr (pool_req.rd_addr),
    .rd_data (pool_rdata)
  );

  // Root pointer of each version
  pva_ram #(
    .ADDR_W (pva_pkg::VER_W),
    .DATA_W (pva_pkg::NODE_W)
  ) u_roots (
    .clk     (clk),
    .wr_en   (root_req.wr_en),
    .wr_addr (root_req.wr_addr),
    .wr_data (root_req.wr_data),
    .rd_en   (root_req.rd_en),
    .rd_addr (root_req.rd_addr),
    .rd_data (root_rdata)
  );

endmodule

FILE: rtl/pva_ram.sv
// ============================================================================
// pva_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ============================================================================
module pva_ram #(
  parameter int ADDR_W = 8,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem_r [2**ADDR_W];
  logic [DATA_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/pva_engine.sv
// ============================================================================
// pva_engine
// Request sequencer: checks, walks one tree path per request through the node
// pool, copies the path on create, and holds the result until taken.
// ============================================================================
module pva_engine (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pva_pkg::LEN_W-1:0]       cfg_wdata,
  pva_in_if.sink                          in_ch,
  pva_out_if.source                       out_ch,
  output pva_pkg::pool_req_t              pool_req,
  input  logic [pva_pkg::WORD_W-1:0]      pool_rdata,
  output pva_pkg::root_req_t              root_req,
  input  logic [pva_pkg::NODE_W-1:0]      root_rdata
);

  localparam int IDX_W  = pva_pkg::IDX_W;
  localparam int LEN_W  = pva_pkg::LEN_W;
  localparam int NODE_W = pva_pkg::NODE_W;
  localparam int FREE_W = pva_pkg::FREE_W;
  localparam int VCNT_W = pva_pkg::VCNT_W;
  localparam int VER_W  = pva_pkg::VER_W;
  localparam int WORD_W = pva_pkg::WORD_W;
  localparam int VAL_W  = pva_pkg::VALUE_W;

  // Control state
  pva_pkg::state_t     state_r,     state_nxt;
  logic [LEN_W-1:0]    len_r,       len_nxt;
  logic [LEN_W-1:0]    loaded_r,    loaded_nxt;
  logic [VCNT_W-1:0]   vtotal_r,    vtotal_nxt;
  logic [FREE_W-1:0]   free_r,      free_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Request payload and walk registers
  logic [pva_pkg::MODE_W-1:0] mode_r, mode_nxt;
  logic [IDX_W-1:0]    idx_r,       idx_nxt;
  logic [VAL_W-1:0]    val_r,       val_nxt;
  logic [IDX_W-1:0]    from_r,      from_nxt;
  logic [IDX_W-1:0]    to_r,        to_nxt;
  logic [FREE_W-1:0]   alloc_r,     alloc_nxt;
  logic [VAL_W-1:0]    res_data_r,  res_data_nxt;
  logic [pva_pkg::STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [VAL_W-1:0]    out_data_r,  out_data_nxt;
  logic [pva_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;

  // Range split and child arithmetic
  logic [IDX_W:0]      mid_sum;
  logic [IDX_W-1:0]    mid;
  logic                go_left;
  logic                at_leaf;
  logic [IDX_W-1:0]    n_last;
  logic [IDX_W:0]      left_span;
  logic [FREE_W-1:0]   lay_left;
  logic [FREE_W-1:0]   lay_right;
  logic [FREE_W-1:0]   alloc_inc;
  logic                alloc_fits;
  logic [NODE_W-1:0]   old_left;
  logic [NODE_W-1:0]   old_right;
  logic [LEN_W:0]      layout_nodes;
  logic [LEN_W-1:0]    loaded_inc;

  assign n_last       = IDX_W'(len_r - 1'b1);
  assign mid_sum      = {1'b0, from_r} + {1'b0, to_r};
  assign mid          = mid_sum[IDX_W:1];
  assign go_left      = (idx_r <= mid);
  assign at_leaf      = (from_r == to_r);
  assign left_span    = {1'b0, mid - from_r} + 1'b1;
  assign lay_left     = alloc_r + 1'b1;
  assign lay_right    = alloc_r + FREE_W'({left_span, 1'b0});
  assign alloc_inc    = alloc_r + 1'b1;
  assign alloc_fits   = (alloc_r < FREE_W'(pva_pkg::POOL_NODES));
  assign old_left     = pool_rdata[NODE_W-1:0];
  assign old_right    = pool_rdata[2*NODE_W-1:NODE_W];
  assign layout_nodes = {len_r, 1'b0} - 1'b1;
  assign loaded_inc   = {1'b0, idx_r} + 1'b1;

  assign in_ch.ready   = (state_r == pva_pkg::S_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.data   = out_data_r;
  assign out_ch.status = out_status_r;

  // Next state and memory requests
  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    loaded_nxt     = loaded_r;
    vtotal_nxt     = vtotal_r;
    free_nxt       = free_r;
    mode_nxt       = mode_r;
    idx_nxt        = idx_r;
    val_nxt        = val_r;
    from_nxt       = from_r;
    to_nxt         = to_r;
    alloc_nxt      = alloc_r;
    res_data_nxt   = res_data_r;
    res_status_nxt = res_status_r;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r;
    pool_req       = '0;
    root_req       = '0;

    // Output register drains on handshake
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      pva_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          mode_nxt       = in_ch.mode;
          idx_nxt        = in_ch.index;
          val_nxt        = in_ch.value;
          from_nxt       = '0;
          to_nxt         = n_last;
          res_data_nxt   = '0;
          res_status_nxt = pva_pkg::ST_OK;
          state_nxt      = pva_pkg::S_RESP;
          case (in_ch.mode)
            pva_pkg::MODE_LOAD: begin
              if ({1'b0, in_ch.index} >= len_r) begin
                res_status_nxt = pva_pkg::ST_BAD_IDX;
              end else if (in_ch.index == '0) begin
                // restart: drop all versions and lay out a fresh tree
                vtotal_nxt = '0;
                loaded_nxt = '0;
                free_nxt   = '0;
                if (32'(layout_nodes) > 32'(pva_pkg::POOL_NODES)) begin
                  res_status_nxt = pva_pkg::ST_FULL;
                end else begin
                  free_nxt  = FREE_W'(layout_nodes);
                  alloc_nxt = '0;
                  state_nxt = pva_pkg::S_LOAD;
                end
              end else if ({1'b0, in_ch.index} == loaded_r) begin
                alloc_nxt = '0;
                state_nxt = pva_pkg::S_LOAD;
              end else begin
                res_status_nxt = pva_pkg::ST_BAD_IDX;
              end
            end
            pva_pkg::MODE_CREATE, pva_pkg::MODE_GET: begin
              if (in_ch.version == '0 || {1'b0, in_ch.version} >= vtotal_r) begin
                res_status_nxt = pva_pkg::ST_BAD_VER;
              end else if ({1'b0, in_ch.index} >= len_r) begin
                res_status_nxt = pva_pkg::ST_BAD_IDX;
              end else if (in_ch.mode == pva_pkg::MODE_CREATE &&
                           vtotal_r >= VCNT_W'(pva_pkg::MAX_VERSIONS)) begin
                res_status_nxt = pva_pkg::ST_FULL;
              end else begin
                root_req.rd_en   = 1'b1;
                root_req.rd_addr = in_ch.version;
                alloc_nxt        = free_r;
                state_nxt        = pva_pkg::S_ROOT;
              end
            end
            default: begin
              // unused code answers zero, ok
            end
          endcase
        end
      end

      // Initial load: node positions follow the preorder layout, no reads
      pva_pkg::S_LOAD: begin
        pool_req.wr_en   = 1'b1;
        pool_req.wr_addr = alloc_r[NODE_W-1:0];
        if (at_leaf) begin
          pool_req.wr_data = WORD_W'(val_r);
          loaded_nxt       = loaded_inc;
          if (loaded_inc == len_r) begin
            root_req.wr_en   = 1'b1;
            root_req.wr_addr = VER_W'(1);
            root_req.wr_data = '0;
            vtotal_nxt       = VCNT_W'(2);
          end
          state_nxt = pva_pkg::S_RESP;
        end else begin
          pool_req.wr_data = WORD_W'({lay_right[NODE_W-1:0], lay_left[NODE_W-1:0]});
          if (go_left) begin
            alloc_nxt = lay_left;
            to_nxt    = mid;
          end else begin
            alloc_nxt = lay_right;
            from_nxt  = mid + 1'b1;
          end
        end
      end

      // Root pointer is back: fetch the root node
      pva_pkg::S_ROOT: begin
        pool_req.rd_en   = 1'b1;
        pool_req.rd_addr = root_rdata;
        state_nxt        = pva_pkg::S_WALK;
      end

      // One tree level per cycle; create writes the copied node alongside
      pva_pkg::S_WALK: begin
        if (at_leaf) begin
          state_nxt = pva_pkg::S_RESP;
          if (mode_r == pva_pkg::MODE_GET) begin
            res_data_nxt = pool_rdata[VAL_W-1:0];
          end else if (alloc_fits) begin
            pool_req.wr_en   = 1'b1;
            pool_req.wr_addr = alloc_r[NODE_W-1:0];
            pool_req.wr_data = WORD_W'(val_r);
            root_req.wr_en   = 1'b1;
            root_req.wr_addr = vtotal_r[VER_W-1:0];
            root_req.wr_data = free_r[NODE_W-1:0];
            res_data_nxt     = VAL_W'(vtotal_r);
            vtotal_nxt       = vtotal_r + 1'b1;
            free_nxt         = alloc_inc;
          end else begin
            res_status_nxt = pva_pkg::ST_FULL;
          end
        end else begin
          pool_req.rd_en = 1'b1;
          // copies past the pool end are never committed
          pool_req.wr_en   = (mode_r == pva_pkg::MODE_CREATE) && alloc_fits;
          pool_req.wr_addr = alloc_r[NODE_W-1:0];
          alloc_nxt        = alloc_inc;
          if (go_left) begin
            pool_req.rd_addr = old_left;
            pool_req.wr_data = WORD_W'({old_right, alloc_inc[NODE_W-1:0]});
            to_nxt           = mid;
          end else begin
            pool_req.rd_addr = old_right;
            pool_req.wr_data = WORD_W'({alloc_inc[NODE_W-1:0], old_left});
            from_nxt         = mid + 1'b1;
          end
        end
      end

      // Hand the result to the output register when it is free
      pva_pkg::S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = res_data_r;
          out_status_nxt = res_status_r;
          state_nxt      = pva_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = pva_pkg::S_IDLE;
      end
    endcase

    // Length write discards every version and any partial load
    if (cfg_we) begin
      if (cfg_wdata == '0) begin
        len_nxt = LEN_W'(1);
      end else if (cfg_wdata > LEN_W'(pva_pkg::MAX_ELEMENTS)) begin
        len_nxt = LEN_W'(pva_pkg::MAX_ELEMENTS);
      end else begin
        len_nxt = cfg_wdata;
      end
      loaded_nxt = '0;
      vtotal_nxt = '0;
      free_nxt   = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pva_pkg::S_IDLE;
      len_r       <= LEN_W'(1);
      loaded_r    <= '0;
      vtotal_r    <= '0;
      free_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      loaded_r    <= loaded_nxt;
      vtotal_r    <= vtotal_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    idx_r        <= idx_nxt;
    val_r        <= val_nxt;
    from_r       <= from_nxt;
    to_r         <= to_nxt;
    alloc_r      <= alloc_nxt;
    res_data_r   <= res_data_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

FILE: rtl/pva_checker.sv
// ============================================================================
// pva_checker
// Port-level checks of the persistent versioned array.
// ============================================================================
module pva_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pva_pkg::VALUE_W-1:0]   out_data,
  input logic [pva_pkg::STATUS_W-1:0]  out_status
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(out_status))
    else $error("result changed while stalled");

  // One request in the engine at a time
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // Every failure answers zero data
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != pva_pkg::ST_OK |-> out_data == '0)
    else $error("failed request returned data");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind persistent_versioned_array pva_checker u_pva_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_data   (out_ch.data),
  .out_status (out_ch.status)
);
